// File: design/bfzp_pkg.sv
`default_nettype none
package bfzp_pkg;

  // Register indexes of the configuration port (byte address 4*index).
  localparam logic [1:0] REG_KERNEL = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Window size limits.
  localparam int unsigned KMIN_FIX = 3;
  localparam int unsigned KMAX_FIX = 15;

  // Reset values of the configuration registers.
  localparam logic [7:0]  KERNEL_RST = 8'd3;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [7:0] pixel;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mean_pixel;
    logic       frame_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_SUM,
    ST_DRAIN,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic write_in;
    logic check;
    logic issue;
    logic drain;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic win_ready;
    logic issue_last;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: design/box_filter_zero_padded_top.sv
// Zero-padded KxK box filter on a raster stream of 8-bit grayscale pixels.
// Input channel in_valid/in_stall/in_item carries one pixel per request, or a
// flush request (flush = 1) that only lets pending results out; the bottom rows
// of a frame need up to K/2 rows plus K/2 of them. Output channel
// out_valid/out_stall/out_item gives at most one mean per request, with
// frame_last on the final one of the frame.
// One request is worked on at a time. A request that gives no result goes
// through the accept, write and check states only. One that gives a result
// then reads the clipped window of R*C pixels (at most K*K) from the line
// store through its single read port, one pixel a cycle, and the mean comes
// from an 8-step restoring divider before it is emitted.
// The output register holds a result while out_stall is high; the next
// request is still taken, and its result waits until the register frees.
// Configuration goes through the APB port (kernel at 0x0, width at 0x4,
// height at 0x8); new values take effect at the next frame.
// Reset (rst_n low, synchronous) restores the register defaults, clears both
// positions and drops any result in the output register. The line store is
// not cleared; it is read only where it was written in the current frame.
`default_nettype none
module box_filter_zero_padded_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bfzp_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bfzp_pkg::out_item_t      out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [7:0]  kernel_r;
  logic [10:0] width_r;
  logic [12:0] height_r;
  bfzp_pkg::dp_cmd_t    cmd;
  bfzp_pkg::dp_status_t status;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= bfzp_pkg::KERNEL_RST;
      width_r  <= bfzp_pkg::WIDTH_RST;
      height_r <= bfzp_pkg::HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        bfzp_pkg::REG_KERNEL: kernel_r <= pwdata[7:0];
        bfzp_pkg::REG_WIDTH:  width_r  <= pwdata[10:0];
        bfzp_pkg::REG_HEIGHT: height_r <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[3:2])
      bfzp_pkg::REG_KERNEL: prdata = {24'd0, kernel_r};
      bfzp_pkg::REG_WIDTH:  prdata = {21'd0, width_r};
      bfzp_pkg::REG_HEIGHT: prdata = {19'd0, height_r};
      default:              prdata = '0;
    endcase
  end

  bfzp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bfzp_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_item        (in_item),
    .kernel_request (kernel_r),
    .image_width    (width_r),
    .image_height   (height_r),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

endmodule
`default_nettype wire

// File: design/bfzp_ram.sv
`default_nettype none
module bfzp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/bfzp_ctrl.sv
`default_nettype none
module bfzp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bfzp_pkg::dp_status_t status,
  output bfzp_pkg::dp_cmd_t         cmd
);

  bfzp_pkg::ctrl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfzp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      bfzp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = bfzp_pkg::ST_WRITE;
        end
      end
      bfzp_pkg::ST_WRITE: begin
        cmd.write_in = 1'b1;
        state_nxt    = bfzp_pkg::ST_CHECK;
      end
      bfzp_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = status.win_ready ? bfzp_pkg::ST_SUM : bfzp_pkg::ST_IDLE;
      end
      bfzp_pkg::ST_SUM: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = bfzp_pkg::ST_DRAIN;
        end
      end
      bfzp_pkg::ST_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = bfzp_pkg::ST_DIV;
      end
      bfzp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = bfzp_pkg::ST_EMIT;
        end
      end
      bfzp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = bfzp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfzp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/bfzp_dp.sv
`default_nettype none
module bfzp_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bfzp_pkg::in_item_t   in_item,
  input  wire logic [7:0]           kernel_request,
  input  wire logic [10:0]          image_width,
  input  wire logic [12:0]          image_height,
  input  wire bfzp_pkg::dp_cmd_t    cmd,
  output bfzp_pkg::dp_status_t      status,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bfzp_pkg::out_item_t       out_item
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RING  = MAX_KERNEL + 1;
  localparam int RW    = $clog2(RING);
  localparam int DEPTH = RING * (2 ** CW);
  localparam int KCAP_M = (MAX_KERNEL - 1) | 1;
  localparam int KCAP  = (KCAP_M < bfzp_pkg::KMAX_FIX) ? KCAP_M : bfzp_pkg::KMAX_FIX;

  // Frame settings latched at the start of a frame; pixel and flush of the current request.
  logic [CW-1:0] wm1_r;
  logic [12:0]   hm1_r;
  logic [2:0]    hk_r;
  logic [7:0]    kk_r;
  logic [7:0]    pixel_r;
  logic          flush_r;

  // Input and output positions.
  logic [12:0]   in_row_r;
  logic [CW-1:0] in_col_r;
  logic [RW-1:0] in_ring_r;
  logic [12:0]   out_row_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_ring_r;

  // Window scan.
  logic [12:0]   rl_r, row_r;
  logic [CW-1:0] cl_r, c0_r, col_r;
  logic [RW-1:0] ring_r;
  logic          rd_valid_r;
  logic [15:0]   acc_r;
  logic [2:0]    div_i_r;
  logic [7:0]    quo_r;

  logic          out_valid_r;
  bfzp_pkg::out_item_t out_item_r;

  logic [7:0]    k8;
  logic [3:0]    k4;
  logic [12:0]   w13;
  logic [12:0]   h13;
  logic          frame_zero;
  logic          in_open;
  logic [13:0]   rl_sum;
  logic [12:0]   rl_win;
  logic [CW:0]   cl_sum;
  logic [CW-1:0] cl_win;
  logic [12:0]   r0_win;
  logic [CW-1:0] c0_win;
  logic [RW:0]   ring0;
  logic          last_out;
  logic [15:0]   div_sub;
  logic [7:0]    rdata;

  // Frame settings from the configuration registers.
  always_comb begin
    if (kernel_request <= 8'd4) begin
      k8 = 8'(bfzp_pkg::KMIN_FIX);
    end else begin
      k8 = (kernel_request - 8'd1) | 8'd1;
    end
    if (k8 > 8'(KCAP)) begin
      k8 = 8'(KCAP);
    end
    k4  = k8[3:0];
    w13 = (image_width == 11'd0) ? 13'd1 : {2'b00, image_width};
    if (w13 > 13'(MAX_WIDTH)) begin
      w13 = 13'(MAX_WIDTH);
    end
    h13 = (image_height == 13'd0) ? 13'd1 : image_height;
  end

  assign frame_zero = (in_row_r == '0) && (in_col_r == '0) &&
                      (out_row_r == '0) && (out_col_r == '0);
  assign in_open    = (in_row_r <= hm1_r);

  // Window bounds of the pending result.
  always_comb begin
    rl_sum = {1'b0, out_row_r} + 14'(hk_r);
    rl_win = (rl_sum > {1'b0, hm1_r}) ? hm1_r : rl_sum[12:0];
    cl_sum = {1'b0, out_col_r} + (CW+1)'(hk_r);
    cl_win = (cl_sum > {1'b0, wm1_r}) ? wm1_r : cl_sum[CW-1:0];
    r0_win = (out_row_r >= 13'(hk_r)) ? out_row_r - 13'(hk_r) : '0;
    c0_win = (out_col_r >= CW'(hk_r)) ? out_col_r - CW'(hk_r) : '0;
    if (out_row_r < 13'(hk_r)) begin
      ring0 = '0;
    end else if ({1'b0, out_ring_r} >= (RW+1)'(hk_r)) begin
      ring0 = {1'b0, out_ring_r} - (RW+1)'(hk_r);
    end else begin
      ring0 = {1'b0, out_ring_r} + (RW+1)'(RING) - (RW+1)'(hk_r);
    end
  end

  // Status toward the controller.
  always_comb begin
    status.win_ready  = (out_row_r <= hm1_r) &&
                        ((in_row_r > rl_win) ||
                         ((in_row_r == rl_win) && (in_col_r > cl_win)));
    status.issue_last = (col_r == cl_r) && (row_r == rl_r);
    status.div_last   = (div_i_r == 3'd0);
    status.out_free   = !out_valid_r || !out_stall;
  end

  assign last_out = (out_row_r == hm1_r) && (out_col_r == wm1_r);
  assign div_sub  = 16'(kk_r) << div_i_r;

  // Line store of recent rows.
  bfzp_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.write_in && !flush_r && in_open),
    .waddr ({in_ring_r, in_col_r}),
    .wdata (pixel_r),
    .raddr ({ring_r, col_r}),
    .rdata (rdata)
  );

  // Request capture and frame latch.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pixel_r <= in_item.pixel;
      flush_r <= in_item.flush;
      if (frame_zero) begin
        wm1_r <= CW'(w13 - 13'd1);
        hm1_r <= h13 - 13'd1;
        hk_r  <= k4[3:1];
        kk_r  <= {4'd0, k4} * {4'd0, k4};
      end
    end
  end

  // Positions in the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
    end else if (cmd.emit && last_out) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
    end else begin
      if (cmd.write_in && !flush_r && in_open) begin
        if (in_col_r == wm1_r) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + 13'd1;
          in_ring_r <= (in_ring_r == RW'(RING - 1)) ? '0 : in_ring_r + RW'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
      if (cmd.emit) begin
        if (out_col_r == wm1_r) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + 13'd1;
          out_ring_r <= (out_ring_r == RW'(RING - 1)) ? '0 : out_ring_r + RW'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  // Window scan over the line store, one pixel a cycle.
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      rl_r   <= rl_win;
      cl_r   <= cl_win;
      c0_r   <= c0_win;
      row_r  <= r0_win;
      col_r  <= c0_win;
      ring_r <= ring0[RW-1:0];
    end else if (cmd.issue && !status.issue_last) begin
      if (col_r == cl_r) begin
        col_r  <= c0_r;
        row_r  <= row_r + 13'd1;
        ring_r <= (ring_r == RW'(RING - 1)) ? '0 : ring_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.issue;
    end
  end

  // Accumulation, then restoring division by K*K on the same register.
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      acc_r <= '0;
    end else if (rd_valid_r) begin
      acc_r <= acc_r + 16'(rdata);
    end else if (cmd.div_step && (acc_r >= div_sub)) begin
      acc_r <= acc_r - div_sub;
    end
    if (cmd.drain) begin
      div_i_r <= 3'd7;
    end else if (cmd.div_step) begin
      div_i_r <= div_i_r - 3'd1;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[6:0], acc_r >= div_sub};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_item_r.mean_pixel <= quo_r;
      out_item_r.frame_last <= last_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// File: design/bfzp_checker.sv
`default_nettype none
module bfzp_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bfzp_pkg::out_item_t out_item,
  input wire logic                pready
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // After an accepted request the block is busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted in back-to-back cycles");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible after reset");

  // A result never appears out of nothing right after an idle cycle.
  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_stall |=> !out_valid)
    else $error("result without a request");

  // The register port never waits.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind box_filter_zero_padded_top bfzp_checker u_bfzp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .pready    (pready)
);
`default_nettype wire

// File: dv/tb_box_filter_zero_padded_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_box_filter_zero_padded_top;

  localparam int MAXW = 1024;
  localparam int RING = 16;
  localparam int CYCLE_LIMIT = 3000000;

  // Scoreboard: holds its own copy of the filter state and predicts means.
  class mean_board;
    logic [7:0] line_mem [RING*MAXW];
    int unsigned kreq, wreg, hreg;
    int unsigned fk, fw, fh;
    int unsigned in_pos, out_pos;
    bfzp_pkg::out_item_t pending_q[$];
    int errors;
    int checked;
    int frames;

    function new();
      kreq = bfzp_pkg::KERNEL_RST;
      wreg = bfzp_pkg::WIDTH_RST;
      hreg = bfzp_pkg::HEIGHT_RST;
      in_pos = 0; out_pos = 0; errors = 0; checked = 0; frames = 0;
      latch_settings();
    endfunction

    function void latch_settings();
      int unsigned k;
      k = kreq & 8'hff;
      if (k <= 4) k = bfzp_pkg::KMIN_FIX;
      else k = (k - 1) | 1;
      if (k > bfzp_pkg::KMAX_FIX) k = bfzp_pkg::KMAX_FIX;
      fk = k;
      fw = wreg & 11'h7ff;
      if (fw == 0) fw = 1;
      if (fw > MAXW) fw = MAXW;
      fh = hreg & 13'h1fff;
      if (fh == 0) fh = 1;
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        bfzp_pkg::REG_KERNEL: kreq = val & 8'hff;
        bfzp_pkg::REG_WIDTH:  wreg = val & 11'h7ff;
        bfzp_pkg::REG_HEIGHT: hreg = val & 13'h1fff;
        default: ;
      endcase
    endfunction

    // Note an accepted input request and queue the result it causes.
    function void note_request(bfzp_pkg::in_item_t it);
      int unsigned total, hk, ro, co, rl, cl, r0, c0, sum;
      bfzp_pkg::out_item_t res;
      if (in_pos == 0 && out_pos == 0) latch_settings();
      total = fw * fh;
      hk = fk / 2;
      if (!it.flush && in_pos < total) begin
        line_mem[((in_pos / fw) % RING) * MAXW + (in_pos % fw)] = it.pixel;
        in_pos++;
      end
      if (out_pos >= total) return;
      ro = out_pos / fw; co = out_pos % fw;
      rl = ro + hk; cl = co + hk;
      if (rl > fh - 1) rl = fh - 1;
      if (cl > fw - 1) cl = fw - 1;
      if (rl * fw + cl >= in_pos) return;
      r0 = (ro >= hk) ? ro - hk : 0;
      c0 = (co >= hk) ? co - hk : 0;
      sum = 0;
      for (int unsigned r = r0; r <= rl; r++)
        for (int unsigned c = c0; c <= cl; c++)
          sum += line_mem[(r % RING) * MAXW + c];
      res.mean_pixel = 8'(sum / (fk * fk));
      res.frame_last = (out_pos == total - 1);
      pending_q.push_back(res);
      out_pos++;
      if (res.frame_last) begin
        in_pos = 0; out_pos = 0; frames++;
        latch_settings();
      end
    endfunction

    // Compare a result with the oldest expectation.
    function void check_result(bfzp_pkg::out_item_t got);
      bfzp_pkg::out_item_t exp_item;
      checked++;
      if (pending_q.size() == 0) begin
        $error("unexpected result mean_pixel %0d", got.mean_pixel);
        errors++;
        return;
      end
      exp_item = pending_q.pop_front();
      if (got.mean_pixel !== exp_item.mean_pixel) begin
        $error("mean_pixel expected %0d actual %0d", exp_item.mean_pixel, got.mean_pixel);
        errors++;
      end
      if (got.frame_last !== exp_item.frame_last) begin
        $error("frame_last expected %0d actual %0d", exp_item.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bfzp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bfzp_pkg::out_item_t out_item;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int sent_count = 0;
  mean_board board;

  always #2 clk = ~clk;

  box_filter_zero_padded_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sample accepted requests on both channels.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_request(in_item);
    if (rst_n && out_valid && !out_stall) board.check_result(out_item);
  end

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic write_cfg(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Send one request; idle gaps come before it at the chosen rate. The
  // task returns at a falling edge with in_valid still high, so the next
  // request or an idle cycle takes over without a gap.
  task automatic send_request(logic [7:0] pix, logic fl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{pixel: pix, flush: fl};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // One whole frame of random pixels, with random flushes between them when noisy, then random requests until it ends.
  task automatic run_frame(int unsigned w, int unsigned h, bit noisy);
    int unsigned n;
    n = w * h;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(9) == 0) send_request(8'($urandom), 1'b1);
      send_request(8'($urandom), 1'b0);
    end
    while (board.out_pos != 0 || board.in_pos != 0)
      send_request(8'($urandom), 1'($urandom));
  endtask

  task automatic set_frame(int unsigned k, int unsigned w, int unsigned h);
    drain_all();
    write_cfg(bfzp_pkg::REG_KERNEL, k);
    write_cfg(bfzp_pkg::REG_WIDTH, w);
    write_cfg(bfzp_pkg::REG_HEIGHT, h);
  endtask

  initial begin
    int unsigned k, w, h;
    board = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: tiny frames, extreme pixels, flush with nothing pending.
    set_frame(0, 1, 1);
    send_request(8'hff, 1'b0);
    send_request(8'h00, 1'b1);
    set_frame(255, 3, 2);
    for (int i = 0; i < 6; i++) send_request((i % 2) ? 8'hff : 8'h00, 1'b0);
    while (board.in_pos != 0 || board.out_pos != 0) send_request(8'hff, 1'b1);
    set_frame(5, 0, 0);
    send_request(8'haa, 1'b0);
    send_request(8'h55, 1'b0);
    set_frame(16, 4, 3);
    for (int i = 0; i < 12; i++) send_request(8'hff, 1'b0);
    send_request(8'h12, 1'b0);
    while (board.in_pos != 0 || board.out_pos != 0) send_request(8'h00, 1'b1);

    // Random frames over three idle phases.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 37 : 0;
      while (sent_count < 630 * (ph + 1)) begin
        k = $urandom_range(255);
        w = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 12);
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        if (w == 0 || w > 40) h = 1;
        if (w > 40 && $urandom_range(1)) w = 1024;
        set_frame(k, w, h);
        run_frame((w == 0) ? 1 : (w > MAXW ? MAXW : w), (h == 0) ? 1 : h,
                  $urandom_range(1));
      end
    end

    // Leave registers at large size values once.
    set_frame(15, 1024, 4096);
    drain_all();

    $display("Sent %0d requests over %0d frames; %0d results checked.",
             sent_count, board.frames, board.checked);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
